### design/brlp_pkg.sv
// Shared types, codes and defaults for the build-rule lexer/parser.
// Used by brlp_lexer, brlp_parser, brlp_outq and build_rule_lexer_parser.
// No dependencies.
package brlp_pkg;

  localparam int MaxDepsDef    = 64;
  localparam int MaxCmdsDef    = 32;
  localparam int OffsetBitsDef = 24;
  localparam int LineBitsDef   = 16;

  // fixed widths of the result fields
  localparam int OffW  = 24;
  localparam int PosW  = 16;
  localparam int RuleW = 16;
  localparam int ItemW = 6;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChSpace   = 8'h20;

  typedef enum logic [1:0] {
    KIND_WORD,
    KIND_COLON,
    KIND_NEWLINE,
    KIND_END
  } kind_e;

  typedef enum logic [1:0] {
    ROLE_TARGET,
    ROLE_DEP,
    ROLE_CMD,
    ROLE_NONE
  } role_e;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_EXP_TARGET,
    ERR_EXP_COLON,
    ERR_EXP_NEWLINE,
    ERR_DEPS,
    ERR_CMDS
  } err_e;

  // token event from the lexer
  typedef struct packed {
    logic             vld;
    kind_e            kind;
    logic [OffW-1:0]  start;
    logic [OffW-1:0]  len;
    logic [PosW-1:0]  line;
    logic [PosW-1:0]  col;
  } tok_t;

  typedef struct packed {
    kind_e            kind;
    role_e            role;
    logic [OffW-1:0]  start;
    logic [OffW-1:0]  len;
    logic [PosW-1:0]  line;
    logic [PosW-1:0]  col;
    logic [RuleW-1:0] rule;
    logic [ItemW-1:0] item;
    err_e             err;
  } res_t;

  // all results of one input word, packed from r0
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } pair_t;

endpackage

### design/build_rule_lexer_parser.sv
// Top level of the build-rule lexer/parser.
// Instantiates brlp_lexer, brlp_parser and brlp_outq; depends on brlp_pkg.

// Takes one text byte (or the end marker) per cycle while in_ready_o is high
// and returns tokens with role, rule/item numbers and error code. Each input
// word is finished in the cycle it is accepted: lexing and the grammar check
// are a single step of registered state, and its zero, one or two tokens go
// into a two-slot result queue. Tokens leave one per cycle while out_ready_i
// is high; a two-token word (one ended by a colon or newline, or flushed by
// the end marker) holds its slot until both go out, else one byte per cycle
// is sustained. in_ready_o is low only while both queue slots are occupied.
// After the end result all state is back at reset, ready for a new text.
module build_rule_lexer_parser #(
  parameter int MAX_DEPENDENCIES = brlp_pkg::MaxDepsDef,
  parameter int MAX_COMMANDS     = brlp_pkg::MaxCmdsDef,
  parameter int OFFSET_BITS      = brlp_pkg::OffsetBitsDef,
  parameter int LINE_BITS        = brlp_pkg::LineBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  token_kind_o,
  output logic [1:0]  token_role_o,
  output logic [23:0] start_offset_o,
  output logic [23:0] token_length_o,
  output logic [15:0] line_number_o,
  output logic [15:0] column_number_o,
  output logic [15:0] rule_number_o,
  output logic [5:0]  item_number_o,
  output logic [2:0]  error_code_o,
  output logic        last_in_run_o
);

  brlp_pkg::tok_t  tok0, tok1;
  brlp_pkg::pair_t pair;
  brlp_pkg::res_t  res;
  logic            step, full;

  assign in_ready_o = !full;
  assign step       = in_valid_i && in_ready_o;

  brlp_lexer #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_lexer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .text_byte_i    (text_byte_i),
    .end_of_input_i (end_of_input_i),
    .tok0_o         (tok0),
    .tok1_o         (tok1)
  );

  brlp_parser #(
    .MAX_DEPENDENCIES (MAX_DEPENDENCIES),
    .MAX_COMMANDS     (MAX_COMMANDS)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .tok0_i (tok0),
    .tok1_i (tok1),
    .pair_o (pair)
  );

  brlp_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step && (pair.cnt != 2'd0)),
    .pair_i  (pair),
    .full_o  (full),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res),
    .last_o  (last_in_run_o)
  );

  assign token_kind_o    = res.kind;
  assign token_role_o    = res.role;
  assign start_offset_o  = res.start;
  assign token_length_o  = res.len;
  assign line_number_o   = res.line;
  assign column_number_o = res.col;
  assign rule_number_o   = res.rule;
  assign item_number_o   = res.item;
  assign error_code_o    = res.err;

  // the end marker always yields a result
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && end_of_input_i |=> out_valid_o)
    else $error("end marker accepted without a result");

  // the end token is always the last of its word
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == brlp_pkg::KIND_END) |-> last_in_run_o)
    else $error("end token not flagged last");

  // an error token carries no role and no item
  a_err_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o != brlp_pkg::ERR_NONE)
      && (token_kind_o != brlp_pkg::KIND_END)
    |-> (token_role_o == brlp_pkg::ROLE_NONE) && (item_number_o == '0))
    else $error("error token with role or item");

  // input stalls only behind pending results
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty result queue");

endmodule

### design/brlp_lexer.sv
// Byte lexer: classifies each byte, tracks offset/line/column and word start,
// and emits up to two token events per byte. Depends on brlp_pkg.
module brlp_lexer #(
  parameter int OFFSET_BITS = brlp_pkg::OffsetBitsDef,
  parameter int LINE_BITS   = brlp_pkg::LineBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        text_byte_i,
  input  logic              end_of_input_i,
  output brlp_pkg::tok_t    tok0_o,
  output brlp_pkg::tok_t    tok1_o
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_COMMENT
  } mode_e;

  mode_e                  mode_q, mode_d, mode_mid;
  logic [OFFSET_BITS-1:0] off_q, off_d, ws_off_q, ws_off_d;
  logic [LINE_BITS-1:0]   line_q, line_d, col_q, col_d;
  logic [LINE_BITS-1:0]   ws_line_q, ws_line_d, ws_col_q, ws_col_d;
  logic                   is_nl, is_colon, is_hash, is_blank, is_sep;

  assign is_nl    = text_byte_i == brlp_pkg::ChNewline;
  assign is_colon = text_byte_i == brlp_pkg::ChColon;
  assign is_hash  = text_byte_i == brlp_pkg::ChHash;
  assign is_blank = (text_byte_i == brlp_pkg::ChSpace) || (text_byte_i == brlp_pkg::ChTab);
  assign is_sep   = is_nl || is_colon || is_blank;

  always_comb begin
    tok0_o.vld   = 1'b0;
    tok0_o.kind  = brlp_pkg::KIND_WORD;
    tok0_o.start = brlp_pkg::OffW'(ws_off_q);
    tok0_o.len   = brlp_pkg::OffW'(off_q - ws_off_q);
    tok0_o.line  = brlp_pkg::PosW'(ws_line_q);
    tok0_o.col   = brlp_pkg::PosW'(ws_col_q);

    tok1_o.vld   = 1'b0;
    tok1_o.kind  = brlp_pkg::KIND_NEWLINE;
    tok1_o.start = brlp_pkg::OffW'(off_q);
    tok1_o.len   = brlp_pkg::OffW'(1);
    tok1_o.line  = brlp_pkg::PosW'(line_q);
    tok1_o.col   = brlp_pkg::PosW'(col_q);

    mode_mid  = MODE_IDLE;
    mode_d    = mode_q;
    off_d     = (off_q == '1) ? off_q : off_q + 1'b1;
    line_d    = line_q;
    col_d     = (col_q == '1) ? col_q : col_q + 1'b1;
    ws_off_d  = ws_off_q;
    ws_line_d = ws_line_q;
    ws_col_d  = ws_col_q;

    if (end_of_input_i) begin
      // flush a pending word, then the end marker; everything restarts
      tok0_o.vld  = mode_q == MODE_WORD;
      tok1_o.vld  = 1'b1;
      tok1_o.kind = brlp_pkg::KIND_END;
      tok1_o.len  = '0;
      tok1_o.line = '0;
      tok1_o.col  = '0;
      mode_d      = MODE_IDLE;
      off_d       = '0;
      line_d      = LINE_BITS'(1);
      col_d       = LINE_BITS'(1);
      ws_off_d    = '0;
      ws_line_d   = '0;
      ws_col_d    = '0;
    end else begin
      case (mode_q)
        MODE_WORD: begin
          if (is_sep) begin
            tok0_o.vld = 1'b1;
            mode_mid   = MODE_IDLE;
          end else begin
            mode_mid = MODE_WORD;
          end
        end
        MODE_COMMENT: mode_mid = is_nl ? MODE_IDLE : MODE_COMMENT;
        default:      mode_mid = MODE_IDLE;
      endcase

      mode_d = mode_mid;
      if (mode_mid == MODE_IDLE) begin
        if (is_nl) begin
          tok1_o.vld = 1'b1;
        end else if (is_colon) begin
          tok1_o.vld  = 1'b1;
          tok1_o.kind = brlp_pkg::KIND_COLON;
        end else if (is_hash) begin
          mode_d = MODE_COMMENT;
        end else if (!is_blank) begin
          mode_d    = MODE_WORD;
          ws_off_d  = off_q;
          ws_line_d = line_q;
          ws_col_d  = col_q;
        end
      end

      if (is_nl) begin
        line_d = (line_q == '1) ? line_q : line_q + 1'b1;
        col_d  = LINE_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      off_q     <= '0;
      line_q    <= LINE_BITS'(1);
      col_q     <= LINE_BITS'(1);
      ws_off_q  <= '0;
      ws_line_q <= '0;
      ws_col_q  <= '0;
    end else if (step_i) begin
      mode_q    <= mode_d;
      off_q     <= off_d;
      line_q    <= line_d;
      col_q     <= col_d;
      ws_off_q  <= ws_off_d;
      ws_line_q <= ws_line_d;
      ws_col_q  <= ws_col_d;
    end
  end

endmodule

### design/brlp_parser.sv
// Grammar checker: runs the two token events of one byte through the rule
// grammar, latches the first error and packs the results. Depends on brlp_pkg.
module brlp_parser #(
  parameter int MAX_DEPENDENCIES = brlp_pkg::MaxDepsDef,
  parameter int MAX_COMMANDS     = brlp_pkg::MaxCmdsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  brlp_pkg::tok_t  tok0_i,
  input  brlp_pkg::tok_t  tok1_i,
  output brlp_pkg::pair_t pair_o
);

  localparam int DepW = $clog2(MAX_DEPENDENCIES + 1);
  localparam int CmdW = $clog2(MAX_COMMANDS + 1);

  typedef enum logic [1:0] {
    PH_TARGET,
    PH_COLON,
    PH_DEPS,
    PH_CMDS
  } phase_e;

  typedef struct packed {
    phase_e                       phase;
    logic [DepW-1:0]              deps;
    logic [CmdW-1:0]              cmds;
    logic [brlp_pkg::RuleW-1:0]   rule;
    brlp_pkg::err_e               err;
  } gst_t;

  typedef struct packed {
    gst_t           st;
    logic           emit;
    brlp_pkg::res_t res;
  } gout_t;

  localparam gst_t StReset = '{
    phase: PH_TARGET, deps: '0, cmds: '0, rule: '0, err: brlp_pkg::ERR_NONE
  };

  function automatic gout_t gstep(input brlp_pkg::tok_t tok, input gst_t st);
    gout_t          o;
    brlp_pkg::err_e err;
    o          = '0;
    o.st       = st;
    o.emit     = 1'b0;
    err        = brlp_pkg::ERR_NONE;
    o.res.kind  = tok.kind;
    o.res.role  = brlp_pkg::ROLE_NONE;
    o.res.start = tok.start;
    o.res.len   = tok.len;
    o.res.line  = tok.line;
    o.res.col   = tok.col;
    o.res.rule  = st.rule;
    o.res.item  = '0;
    o.res.err   = brlp_pkg::ERR_NONE;
    if (tok.vld && (st.err == brlp_pkg::ERR_NONE)) begin
      o.emit = 1'b1;
      case (st.phase)
        PH_TARGET: begin
          if (tok.kind == brlp_pkg::KIND_WORD) begin
            o.res.role = brlp_pkg::ROLE_TARGET;
            o.st.phase = PH_COLON;
          end else if (tok.kind == brlp_pkg::KIND_COLON) begin
            err = brlp_pkg::ERR_EXP_TARGET;
          end
        end
        PH_COLON: begin
          if (tok.kind == brlp_pkg::KIND_COLON) o.st.phase = PH_DEPS;
          else                                  err = brlp_pkg::ERR_EXP_COLON;
        end
        PH_DEPS: begin
          if (tok.kind == brlp_pkg::KIND_WORD) begin
            if (st.deps >= DepW'(MAX_DEPENDENCIES)) begin
              err = brlp_pkg::ERR_DEPS;
            end else begin
              o.res.role = brlp_pkg::ROLE_DEP;
              o.res.item = brlp_pkg::ItemW'(st.deps);
              o.st.deps  = st.deps + 1'b1;
            end
          end else if (tok.kind == brlp_pkg::KIND_NEWLINE) begin
            o.st.phase = PH_CMDS;
          end else begin
            err = brlp_pkg::ERR_EXP_NEWLINE;
          end
        end
        PH_CMDS: begin
          if (tok.kind == brlp_pkg::KIND_WORD) begin
            if (st.cmds >= CmdW'(MAX_COMMANDS)) begin
              err = brlp_pkg::ERR_CMDS;
            end else begin
              o.res.role = brlp_pkg::ROLE_CMD;
              o.res.item = brlp_pkg::ItemW'(st.cmds);
              o.st.cmds  = st.cmds + 1'b1;
            end
          end else if (tok.kind == brlp_pkg::KIND_NEWLINE) begin
            // any newline in the command phase closes the rule
            o.st.rule  = (st.rule == '1) ? st.rule : st.rule + 1'b1;
            o.st.phase = PH_TARGET;
            o.st.deps  = '0;
            o.st.cmds  = '0;
          end else begin
            err = brlp_pkg::ERR_EXP_NEWLINE;
          end
        end
        default: ;
      endcase
      if (err != brlp_pkg::ERR_NONE) begin
        o.st.err   = err;
        o.res.role = brlp_pkg::ROLE_NONE;
        o.res.item = '0;
        o.res.err  = err;
      end
    end
    return o;
  endfunction

  gst_t           st_q, st_d;
  gout_t          g0, g1;
  brlp_pkg::res_t r1;
  brlp_pkg::err_e end_err;
  logic           e1;

  always_comb begin
    g0      = gstep(tok0_i, st_q);
    g1      = gstep(tok1_i, g0.st);
    st_d    = g1.st;
    r1      = g1.res;
    e1      = g1.emit;
    end_err = g0.st.err;
    if (tok1_i.vld && (tok1_i.kind == brlp_pkg::KIND_END)) begin
      if (end_err == brlp_pkg::ERR_NONE) begin
        case (g0.st.phase)
          PH_COLON: end_err = brlp_pkg::ERR_EXP_COLON;
          PH_DEPS:  end_err = brlp_pkg::ERR_EXP_NEWLINE;
          PH_CMDS:  end_err = brlp_pkg::ERR_EXP_NEWLINE;
          default:  end_err = brlp_pkg::ERR_NONE;
        endcase
      end
      r1.kind  = brlp_pkg::KIND_END;
      r1.role  = brlp_pkg::ROLE_NONE;
      r1.start = tok1_i.start;
      r1.len   = '0;
      r1.line  = '0;
      r1.col   = '0;
      r1.rule  = g0.st.rule;
      r1.item  = '0;
      r1.err   = end_err;
      e1       = 1'b1;
      st_d     = StReset;
    end

    pair_o.cnt = {1'b0, g0.emit} + {1'b0, e1};
    pair_o.r0  = g0.emit ? g0.res : r1;
    pair_o.r1  = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StReset;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

endmodule

### design/brlp_outq.sv
// Result queue: two slots, each holding all results of one input word,
// shown one result per handshake with the last-of-word flag. Depends on brlp_pkg.
module brlp_outq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  brlp_pkg::pair_t pair_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            ready_i,
  output brlp_pkg::res_t  res_o,
  output logic            last_o
);

  brlp_pkg::pair_t slot_q [2];
  brlp_pkg::pair_t head;
  logic            wr_q, rd_q, sel_q;
  logic [1:0]      cnt_q;
  logic            fire, pop;

  assign head    = slot_q[rd_q];
  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign last_o  = sel_q || (head.cnt == 2'd1);
  assign res_o   = sel_q ? head.r1 : head.r0;
  assign fire    = valid_o && ready_i;
  assign pop     = fire && last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      sel_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop)    rd_q <= ~rd_q;
      if (fire)   sel_q <= ~last_o;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= pair_i;
  end

endmodule
